/* rtl/slpd_pkg.sv */
`default_nettype none

package slpd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 31;
    localparam int unsigned HDR_CNT_W = 3;
    localparam int unsigned HDR_KEEP_W = 56;

    localparam logic [31:0]      SIGNATURE_WORD = 32'hdeadbeef;
    localparam logic [LEN_W-1:0] DEFAULT_MAX_PACKET = 31'd10240;

    typedef enum logic [1:0] {
        KIND_BODY    = 2'd0,
        KIND_BAD_SIG = 2'd1,
        KIND_BAD_LEN = 2'd2
    } t_kind;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] body_data;
        logic              first;
        logic              last;
        t_kind             kind;
    } t_result;

endpackage

`default_nettype wire

/* rtl/slpd_parse.sv */
`default_nettype none

module slpd_parse (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_advance,
    input  wire logic [slpd_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic [slpd_pkg::LEN_W-1:0]    i_max_packet_size,
    output slpd_pkg::t_result                  o_result
);
    import slpd_pkg::*;

    logic                  r_want_header;
    logic [HDR_CNT_W-1:0]  r_header_count;
    logic [HDR_KEEP_W-1:0] r_header_shift;
    logic [LEN_W-1:0]      r_body_remaining;
    logic                  r_at_body_start;

    logic                  n_want_header;
    logic [HDR_CNT_W-1:0]  n_header_count;
    logic [HDR_KEEP_W-1:0] n_header_shift;
    logic [LEN_W-1:0]      n_body_remaining;
    logic                  n_at_body_start;

    logic [63:0]           full_header;
    logic [31:0]           sig_word;
    logic [31:0]           len_word;
    logic [LEN_W-1:0]      remaining_dec;

    assign full_header   = {r_header_shift, i_byte};
    assign sig_word      = full_header[63:32];
    assign len_word      = full_header[31:0];
    assign remaining_dec = r_body_remaining - LEN_W'(1);

    always_comb begin
        n_want_header    = r_want_header;
        n_header_count   = r_header_count;
        n_header_shift   = r_header_shift;
        n_body_remaining = r_body_remaining;
        n_at_body_start  = r_at_body_start;
        o_result         = '0;
        o_result.kind    = KIND_BODY;

        if (r_want_header || r_body_remaining == '0) begin
            n_want_header  = 1'b1;
            n_header_shift = full_header[HDR_KEEP_W-1:0];
            n_header_count = r_header_count + HDR_CNT_W'(1);
            if (r_header_count == '1) begin
                n_header_shift = '0;
                if (sig_word != SIGNATURE_WORD) begin
                    o_result.valid = 1'b1;
                    o_result.kind  = KIND_BAD_SIG;
                end else if (len_word[31] || len_word[LEN_W-1:0] > i_max_packet_size) begin
                    o_result.valid = 1'b1;
                    o_result.kind  = KIND_BAD_LEN;
                end else if (len_word != '0) begin
                    n_body_remaining = len_word[LEN_W-1:0];
                    n_want_header    = 1'b0;
                    n_at_body_start  = 1'b1;
                end
            end
        end else begin
            o_result.valid     = 1'b1;
            o_result.body_data = i_byte;
            o_result.first     = r_at_body_start;
            o_result.last      = (r_body_remaining == LEN_W'(1));
            o_result.kind      = KIND_BODY;
            n_at_body_start    = 1'b0;
            n_body_remaining   = remaining_dec;
            if (remaining_dec == '0) begin
                n_want_header  = 1'b1;
                n_header_count = '0;
                n_header_shift = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_want_header    <= 1'b1;
            r_header_count   <= '0;
            r_header_shift   <= '0;
            r_body_remaining <= '0;
            r_at_body_start  <= 1'b0;
        end else if (i_advance) begin
            r_want_header    <= n_want_header;
            r_header_count   <= n_header_count;
            r_header_shift   <= n_header_shift;
            r_body_remaining <= n_body_remaining;
            r_at_body_start  <= n_at_body_start;
        end
    end

endmodule

`default_nettype wire

/* rtl/signature_length_packet_deframer_unit.sv */
// Datapath: input register, combinational parser, then result register.
// Throughput: one stream byte per cycle; the input register and the result register
// each take a new transfer whenever the result register is empty or being drained.
// Reset: synchronous, active low; clears both pipeline registers, restarts header
// hunting and loads max_packet_size with 10240.
`default_nettype none

module signature_length_packet_deframer_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output      logic                          o_in_stall,
    input  wire logic [slpd_pkg::BYTE_W-1:0]   i_stream_byte,
    output      logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    output      logic [slpd_pkg::BYTE_W-1:0]   o_body_byte,
    output      logic                          o_first_of_packet,
    output      logic                          o_last_of_packet,
    output      logic [1:0]                    o_result_kind,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output      logic [31:0]                   prdata,
    output      logic                          pready
);
    import slpd_pkg::*;

    logic [LEN_W-1:0]  r_max_packet_size;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;

    logic              out_free;
    logic              advance;
    t_result           parse_result;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {1'b0, r_max_packet_size} : '0;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_packet_size <= DEFAULT_MAX_PACKET;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_max_packet_size <= pwdata[LEN_W-1:0];
        end
    end

    slpd_parse u_parse (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_advance         (advance),
        .i_byte            (r_in_byte),
        .i_max_packet_size (r_max_packet_size),
        .o_result          (parse_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (out_free || !r_in_valid) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free || !r_in_valid) begin
            r_in_byte <= i_stream_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid && parse_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= parse_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_body_byte       = r_out.body_data;
    assign o_first_of_packet = r_out.first;
    assign o_last_of_packet  = r_out.last;
    assign o_result_kind     = r_out.kind;

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_result_kind == KIND_BODY || o_result_kind == KIND_BAD_SIG
                         || o_result_kind == KIND_BAD_LEN))
        else $error("result kind out of range");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind != KIND_BODY)
            |-> (o_body_byte == '0 && !o_first_of_packet && !o_last_of_packet))
        else $error("error result carries body fields");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input transfer lost");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with free result register");

endmodule

`default_nettype wire
